// ===== src/sair_pkg.sv =====
package sair_pkg;

  localparam int IDX_W  = 5;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int KIND_W = 2;

  // Width for slot positions and lengths in comparisons.
  // It covers every supported capacity (up to 256) and the full range of the index field.
  localparam int CTRL_W = 10;

  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_DATA_WIDTH = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_CREATE = 2'd3
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_CAP   = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_INS,
    CELL_REM,
    CELL_CLR
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t         cmd;
    logic [CTRL_W-1:0] pos;
    logic [CTRL_W-1:0] last;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_EXEC
  } state_t;

endpackage

// ===== src/sair_cell.sv =====
module sair_cell #(
  parameter int IDX        = 0,
  parameter int DATA_WIDTH = sair_pkg::DEF_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sair_pkg::cell_ctrl_t  ctrl,
  input  logic [DATA_WIDTH-1:0] load_value,
  input  logic [DATA_WIDTH-1:0] left_value,
  input  logic                  left_full,
  input  logic [DATA_WIDTH-1:0] right_value,
  input  logic                  right_full,
  output logic [DATA_WIDTH-1:0] value,
  output logic                  full
);
  import sair_pkg::*;

  localparam logic [CTRL_W-1:0] MY_IDX = CTRL_W'(IDX);

  logic                  take_load;
  logic                  take_left;
  logic                  take_right;
  logic                  drop;

  always_comb begin
    take_load  = 1'b0;
    take_left  = 1'b0;
    take_right = 1'b0;
    drop       = 1'b0;
    case (ctrl.cmd)
      CELL_LOAD: begin
        take_load = (MY_IDX == ctrl.pos);
      end
      CELL_INS: begin
        take_load = (MY_IDX == ctrl.pos);
        take_left = (MY_IDX > ctrl.pos) && (MY_IDX <= ctrl.last);
      end
      CELL_REM: begin
        // The last slot within the length always ends up empty after a remove.
        drop       = (MY_IDX == ctrl.last);
        take_right = (MY_IDX >= ctrl.pos) && (MY_IDX < ctrl.last);
      end
      CELL_CLR: begin
        drop = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (take_load) begin
      full <= 1'b1;
    end else if (take_left) begin
      full <= left_full;
    end else if (take_right) begin
      full <= right_full;
    end else if (drop) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_load) begin
      value <= load_value;
    end else if (take_left) begin
      value <= left_value;
    end else if (take_right) begin
      value <= right_value;
    end
  end

endmodule

// ===== src/slot_array_insert_remove.sv =====
// Slotted array of CAPACITY entries held in a row of cells. Each cell holds one entry and can
// take its neighbor's entry on an insert or a remove. First the operation is captured when the
// item is transferred. In the lookup state the occupancy and value at the addressed slot and at
// the last slot are read from the row. In the execute state the decision is broadcast, the cells
// shift, load or clear in parallel, and the result is registered. A new item is taken once the
// previous one has reached the result register, even while that result is still stalled. The
// next item's execution then waits until the result has been taken.
module slot_array_insert_remove #(
  parameter int CAPACITY   = sair_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = sair_pkg::DEF_DATA_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [sair_pkg::KIND_W-1:0]   kind,
  input  logic [sair_pkg::IDX_W-1:0]    index,
  input  logic [sair_pkg::VAL_W-1:0]    value,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [sair_pkg::VAL_W-1:0]    removed_value,
  output logic [sair_pkg::STAT_W-1:0]   status,
  output logic [sair_pkg::IDX_W-1:0]    occupied_count,
  output logic [sair_pkg::IDX_W-1:0]    length_now,
  output logic                          is_empty
);
  import sair_pkg::*;

  localparam int LEN_W = $clog2(CAPACITY + 1);
  localparam logic [CTRL_W-1:0] CAP_C = CTRL_W'(CAPACITY);
  localparam logic [CTRL_W-1:0] ONE_C = CTRL_W'(1);

  state_t                  state;
  state_t                  state_next;

  kind_t                   op_kind;
  logic [CTRL_W-1:0]       op_pos;
  logic [DATA_WIDTH-1:0]   op_value;

  logic                    lk_full_pos;
  logic                    lk_full_last;
  logic [DATA_WIDTH-1:0]   lk_value;
  logic                    hit_full_pos;
  logic                    hit_full_last;
  logic [DATA_WIDTH-1:0]   hit_value;

  logic [LEN_W-1:0]        length;
  logic [LEN_W-1:0]        length_next;
  logic [LEN_W-1:0]        count;
  logic [LEN_W-1:0]        count_next;
  logic [CTRL_W-1:0]       len_ext;
  logic [CTRL_W-1:0]       last_idx;
  logic [CTRL_W-1:0]       grown_len;

  status_t                 st_next;
  logic [DATA_WIDTH-1:0]   taken_next;
  cell_ctrl_t              exec_ctrl;
  cell_ctrl_t              ctrl;
  logic                    exec_go;
  logic                    item_take;

  logic [DATA_WIDTH-1:0]   cell_value [CAPACITY];
  logic                    cell_full  [CAPACITY];

  assign len_ext   = CTRL_W'(length);
  assign last_idx  = len_ext - ONE_C;
  assign item_take = item_valid && !item_stall;
  assign exec_go   = (state == S_EXEC) && (!result_valid || !result_stall);

  // Row of slot cells; the end cells see empty neighbors.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] lv;
    logic                  lf;
    logic [DATA_WIDTH-1:0] rv;
    logic                  rf;
    if (g == 0) begin : g_left_end
      assign lv = '0;
      assign lf = 1'b0;
    end else begin : g_left
      assign lv = cell_value[g-1];
      assign lf = cell_full[g-1];
    end
    if (g == CAPACITY - 1) begin : g_right_end
      assign rv = '0;
      assign rf = 1'b0;
    end else begin : g_right
      assign rv = cell_value[g+1];
      assign rf = cell_full[g+1];
    end
    sair_cell #(
      .IDX        (g),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .load_value  (op_value),
      .left_value  (lv),
      .left_full   (lf),
      .right_value (rv),
      .right_full  (rf),
      .value       (cell_value[g]),
      .full        (cell_full[g])
    );
  end

  // Select the addressed slot and the last slot; at most one cell matches each of them.
  always_comb begin
    hit_full_pos  = 1'b0;
    hit_full_last = 1'b0;
    hit_value     = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (CTRL_W'(i) == op_pos) begin
        hit_full_pos = cell_full[i];
        hit_value    = cell_value[i];
      end
      if (CTRL_W'(i) == last_idx) begin
        hit_full_last = cell_full[i];
      end
    end
  end

  // Decision for the captured operation.
  always_comb begin
    st_next        = ST_OK;
    taken_next     = '0;
    length_next    = length;
    count_next     = count;
    grown_len      = len_ext + CTRL_W'(lk_full_last);
    exec_ctrl.cmd  = CELL_HOLD;
    exec_ctrl.pos  = op_pos;
    exec_ctrl.last = last_idx;
    case (op_kind)
      KIND_INSERT: begin
        if (op_pos >= len_ext) begin
          if (op_pos + ONE_C > CAP_C) begin
            st_next = ST_CAP;
          end else begin
            exec_ctrl.cmd = CELL_LOAD;
            length_next   = LEN_W'(op_pos + ONE_C);
            count_next    = count + LEN_W'(1);
          end
        end else if (!lk_full_pos) begin
          exec_ctrl.cmd = CELL_LOAD;
          count_next    = count + LEN_W'(1);
        end else if (lk_full_last && (len_ext == CAP_C)) begin
          st_next = ST_CAP;
        end else begin
          exec_ctrl.cmd  = CELL_INS;
          exec_ctrl.last = grown_len - ONE_C;
          length_next    = LEN_W'(grown_len);
          count_next     = count + LEN_W'(1);
        end
      end
      KIND_REMOVE: begin
        if (op_pos >= len_ext) begin
          st_next = ST_RANGE;
        end else if (!lk_full_pos) begin
          st_next = ST_EMPTY;
        end else begin
          exec_ctrl.cmd = CELL_REM;
          taken_next    = lk_value;
          count_next    = count - LEN_W'(1);
        end
      end
      KIND_CLEAR: begin
        exec_ctrl.cmd = CELL_CLR;
        count_next    = '0;
      end
      KIND_CREATE: begin
        if (op_pos > CAP_C) begin
          st_next = ST_CAP;
        end else begin
          exec_ctrl.cmd = CELL_CLR;
          length_next   = LEN_W'(op_pos);
          count_next    = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (exec_go) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    item_stall = 1'b1;
    ctrl       = '{cmd: CELL_HOLD, pos: '0, last: '0};
    case (state)
      S_IDLE: begin
        item_stall = 1'b0;
      end
      S_EXEC: begin
        if (exec_go) begin
          ctrl = exec_ctrl;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      length       <= '0;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (exec_go) begin
        length       <= length_next;
        count        <= count_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      op_kind  <= kind_t'(kind);
      op_pos   <= CTRL_W'(index);
      op_value <= DATA_WIDTH'(value);
    end
    if (state == S_LOOK) begin
      lk_full_pos  <= hit_full_pos;
      lk_full_last <= hit_full_last;
      lk_value     <= hit_value;
    end
    if (exec_go) begin
      removed_value  <= VAL_W'(taken_next);
      status         <= st_next;
      occupied_count <= IDX_W'(count_next);
      length_now     <= IDX_W'(length_next);
      is_empty       <= (count_next == '0);
    end
  end

  a_count_within_length: assert property (@(posedge clk) disable iff (rst)
    count <= length)
    else $error("occupied count exceeds the array length");

  a_take_starts_lookup: assert property (@(posedge clk) disable iff (rst)
    item_take |=> state == S_LOOK)
    else $error("accepted item did not enter the lookup cycle");

  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_EXEC)
    else $error("result appeared without an execute cycle");

  a_no_shift_outside_exec: assert property (@(posedge clk) disable iff (rst)
    state != S_EXEC |-> ctrl.cmd == CELL_HOLD)
    else $error("cell row commanded outside the execute cycle");

endmodule
